/* rtl/core/sorted_priority_queue_macros.svh */
// Assertion macros shared by the checker of the sorted priority queue.
`ifndef SORTED_PRIORITY_QUEUE_MACROS_SVH
`define SORTED_PRIORITY_QUEUE_MACROS_SVH

// Same-cycle implication, off while reset is low.
`define SPQ_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, off while reset is low.
`define SPQ_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/core/spq_pkg.sv */
// Package: shared types and constants of the sorted priority queue.
`timescale 1ns / 1ps
package spq_pkg;

    localparam int unsigned DEF_CAPACITY = 16;
    localparam int unsigned VALUE_W      = 32;
    localparam int unsigned COUNT_W      = 5;

    localparam logic OP_INSERT = 1'b0;
    localparam logic OP_REMOVE = 1'b1;

    typedef enum logic [1:0] {
        ST_DONE  = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2
    } spq_status_t;

    // broadcast to every cell of the row
    typedef struct packed {
        logic ins;
        logic rem;
    } spq_ctl_t;

endpackage

/* rtl/core/spq_cell.sv */
// One cell of the sorted row: holds an entry and its valid flag.
`timescale 1ns / 1ps
module spq_cell
    import spq_pkg::*;
(
    input  logic                      aclk,
    input  logic                      aresetn,
    input  spq_ctl_t                  ctl,
    input  logic signed [VALUE_W-1:0] ins_value,
    input  logic signed [VALUE_W-1:0] left_entry,
    input  logic                      left_valid,
    input  logic                      left_take,
    input  logic signed [VALUE_W-1:0] right_entry,
    input  logic                      right_valid,
    output logic signed [VALUE_W-1:0] entry,
    output logic                      valid,
    output logic                      take
);

    logic signed [VALUE_W-1:0] entry_reg, entry_next;
    logic                      valid_reg, valid_next;

    // empty slot or larger entry: insert lands here or further left
    assign take = !valid_reg || (entry_reg > ins_value);

    always_comb begin
        entry_next = entry_reg;
        valid_next = valid_reg;
        if (ctl.ins) begin
            if (left_take) begin
                entry_next = left_entry;
            end else if (take) begin
                entry_next = ins_value;
            end
            valid_next = valid_reg | left_valid;
        end else if (ctl.rem) begin
            entry_next = right_entry;
            valid_next = right_valid;
        end
    end

    always_ff @(posedge aclk) begin
        entry_reg <= entry_next;
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    assign entry = entry_reg;
    assign valid = valid_reg;

endmodule

/* rtl/core/sorted_priority_queue.sv */
// Top level: ascending priority queue built from a row of compare-and-shift cells.
//
//  channel | ports                                     | direction
//  --------+-------------------------------------------+----------
//  input   | s_valid s_ready s_opcode s_value          | in
//  result  | m_valid m_ready m_status m_removed_value  | out
//          | m_entry_count                             |
//
// Every cell compares its entry with the broadcast insert value and shifts
// against its neighbor in the same cycle as the item is accepted, so the
// cell row updates once per accepted item.
// Results sit in an output register; s_ready is high when that register is
// empty or being drained, so the input stalls for as long as m_ready holds
// back a waiting result.
// Reset (aresetn low, synchronous) empties the queue and the output register.
`timescale 1ns / 1ps
module sorted_priority_queue
    import spq_pkg::*;
#(
    parameter int unsigned CAPACITY = DEF_CAPACITY
) (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      s_valid,
    output logic                      s_ready,
    input  logic                      s_opcode,
    input  logic signed [VALUE_W-1:0] s_value,
    output logic                      m_valid,
    input  logic                      m_ready,
    output logic [1:0]                m_status,
    output logic signed [VALUE_W-1:0] m_removed_value,
    output logic [COUNT_W-1:0]        m_entry_count
);

    localparam int unsigned OccW = $clog2(CAPACITY + 1);

    // cell row wiring
    logic signed [VALUE_W-1:0] cell_entry [CAPACITY];
    logic                      cell_valid [CAPACITY];
    logic                      cell_take  [CAPACITY];

    logic [OccW-1:0]           occ_reg, occ_next;
    logic                      m_valid_reg, m_valid_next;
    spq_status_t               status_reg, status_next;
    logic signed [VALUE_W-1:0] removed_reg, removed_next;
    logic [OccW+COUNT_W-1:0]   count_ext;

    logic     accept;
    logic     q_full;
    logic     q_empty;
    spq_ctl_t ctl;

    assign s_ready = !m_valid_reg || m_ready;
    assign accept  = s_valid && s_ready;
    assign q_full  = (occ_reg == OccW'(CAPACITY));
    assign q_empty = (occ_reg == '0);

    assign ctl.ins = accept && (s_opcode == OP_INSERT) && !q_full;
    assign ctl.rem = accept && (s_opcode == OP_REMOVE) && !q_empty;

    // cell 0 holds the smallest entry; inserts shift right, removes shift left
    for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
        logic signed [VALUE_W-1:0] l_entry, r_entry;
        logic                      l_valid, l_take, r_valid;

        if (i == 0) begin : g_head
            assign l_entry = '0;
            assign l_valid = 1'b1;
            assign l_take  = 1'b0;
        end else begin : g_mid
            assign l_entry = cell_entry[i-1];
            assign l_valid = cell_valid[i-1];
            assign l_take  = cell_take[i-1];
        end

        if (i == CAPACITY - 1) begin : g_tail
            assign r_entry = '0;
            assign r_valid = 1'b0;
        end else begin : g_body
            assign r_entry = cell_entry[i+1];
            assign r_valid = cell_valid[i+1];
        end

        spq_cell u_cell (
            .aclk        (aclk),
            .aresetn     (aresetn),
            .ctl         (ctl),
            .ins_value   (s_value),
            .left_entry  (l_entry),
            .left_valid  (l_valid),
            .left_take   (l_take),
            .right_entry (r_entry),
            .right_valid (r_valid),
            .entry       (cell_entry[i]),
            .valid       (cell_valid[i]),
            .take        (cell_take[i])
        );
    end

    always_comb begin
        occ_next     = occ_reg;
        m_valid_next = m_valid_reg && !m_ready;
        status_next  = status_reg;
        removed_next = removed_reg;
        if (accept) begin
            m_valid_next = 1'b1;
            removed_next = '0;
            unique case (s_opcode)
                OP_INSERT: begin
                    if (q_full) begin
                        status_next = ST_FULL;
                    end else begin
                        status_next = ST_DONE;
                        occ_next    = occ_reg + 1'b1;
                    end
                end
                OP_REMOVE: begin
                    if (q_empty) begin
                        status_next = ST_EMPTY;
                    end else begin
                        status_next  = ST_DONE;
                        removed_next = cell_entry[0];
                        occ_next     = occ_reg - 1'b1;
                    end
                end
                default: status_next = status_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        status_reg  <= status_next;
        removed_reg <= removed_next;
        if (!aresetn) begin
            occ_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            occ_reg     <= occ_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // count reported modulo 32, carried with the result
    logic [OccW-1:0] count_reg;

    always_ff @(posedge aclk) begin
        if (accept) begin
            count_reg <= occ_next;
        end
    end

    assign count_ext       = {{COUNT_W{1'b0}}, count_reg};
    assign m_entry_count   = count_ext[COUNT_W-1:0];
    assign m_valid         = m_valid_reg;
    assign m_status        = status_reg;
    assign m_removed_value = removed_reg;

endmodule

/* rtl/core/spq_checker.sv */
// Checker on the ports of the sorted priority queue, bound to the top level.
`timescale 1ns / 1ps
`include "sorted_priority_queue_macros.svh"
module spq_checker
    import spq_pkg::*;
#(
    parameter int unsigned CAPACITY = DEF_CAPACITY
) (
    input logic                      aclk,
    input logic                      aresetn,
    input logic                      s_valid,
    input logic                      s_ready,
    input logic                      s_opcode,
    input logic signed [VALUE_W-1:0] s_value,
    input logic                      m_valid,
    input logic                      m_ready,
    input logic [1:0]                m_status,
    input logic signed [VALUE_W-1:0] m_removed_value,
    input logic [COUNT_W-1:0]        m_entry_count
);

    localparam int unsigned FullCount = CAPACITY % (2 ** COUNT_W);

    logic unused_in;
    assign unused_in = s_valid ^ s_ready ^ s_opcode ^ s_value[0];

    `SPQ_ASSERT_NOW(a_empty_count, m_valid && (m_status == ST_EMPTY), m_entry_count == '0, "failed remove must report an empty queue")
    `SPQ_ASSERT_NOW(a_full_count, m_valid && (m_status == ST_FULL), m_entry_count == COUNT_W'(FullCount), "dropped insert must report a full queue")
    `SPQ_ASSERT_NOW(a_fail_zero, m_valid && (m_status != ST_DONE), m_removed_value == '0, "failed operation must report zero")
    `SPQ_ASSERT_NEXT(a_hold, m_valid && !m_ready, m_valid && $stable(m_removed_value) && $stable(m_entry_count), "stalled result changed")

endmodule

bind sorted_priority_queue spq_checker #(.CAPACITY(CAPACITY)) u_spq_checker (.*);

/* dv/tb_sorted_priority_queue.sv */
`timescale 1ns / 1ps
// Self-checking testbench for the sorted priority queue: shadow sorted list, random traffic.
module tb_sorted_priority_queue;
    import spq_pkg::*;

    localparam int unsigned CAP         = DEF_CAPACITY;
    localparam int unsigned HOLD_CYCLES = 120;  // long receiver hold-off, fills the pipe
    localparam int unsigned SEGMENTS    = 14;
    localparam int unsigned SEG_ITEMS   = 38;
    localparam int unsigned CALM_FROM   = 11;   // segments from here on run without idling
    localparam int unsigned MAX_REPORTS = 10;

    // One result item as the block should report it.
    typedef struct packed {
        spq_status_t               status;
        logic signed [VALUE_W-1:0] removed_value;
        logic [COUNT_W-1:0]        entry_count;
    } pq_result_t;

    // Shadow of the queue contents plus the results still owed by the block.
    class pq_scoreboard;
        logic signed [VALUE_W-1:0] held[$];     // ascending, smallest at index 0
        pq_result_t                awaited[$];  // oldest first
        int unsigned               capacity;
        int unsigned               mismatches;

        function new(int unsigned cap);
            capacity   = cap;
            mismatches = 0;
        endfunction

        // Apply one accepted item to the shadow list and queue up its result.
        function void note_item(logic op, logic signed [VALUE_W-1:0] val);
            pq_result_t  r;
            int unsigned pos;
            r.status        = ST_DONE;
            r.removed_value = '0;
            if (op == OP_INSERT) begin
                if (held.size() >= capacity) begin
                    r.status = ST_FULL;
                end else begin
                    // stable: goes after every entry <= val
                    pos = 0;
                    while (pos < held.size() && !(held[pos] > val))
                        pos++;
                    held.insert(pos, val);
                end
            end else if (held.size() == 0) begin
                r.status = ST_EMPTY;
            end else begin
                r.removed_value = held.pop_front();
            end
            r.entry_count = COUNT_W'(held.size());
            awaited.push_back(r);
        endfunction

        function void check_result(logic [1:0] st, logic signed [VALUE_W-1:0] rv,
                                   logic [COUNT_W-1:0] cnt);
            pq_result_t want;
            if (awaited.size() == 0) begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("%0t: result with nothing pending: status %0d value %0d count %0d",
                             $realtime, st, rv, cnt);
                return;
            end
            want = awaited.pop_front();
            if (st !== want.status || rv !== want.removed_value || cnt !== want.entry_count) begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("%0t: mismatch: status exp %0d got %0d, value exp %0d got %0d, count exp %0d got %0d",
                             $realtime, want.status, st, want.removed_value, rv,
                             want.entry_count, cnt);
            end
        endfunction
    endclass

    logic                      aclk            = 1'b0;
    logic                      aresetn         = 1'b0;
    logic                      s_valid         = 1'b0;
    logic                      s_ready;
    logic                      s_opcode        = OP_INSERT;
    logic signed [VALUE_W-1:0] s_value         = '0;
    logic                      m_valid;
    logic                      m_ready         = 1'b0;
    logic [1:0]                m_status;
    logic signed [VALUE_W-1:0] m_removed_value;
    logic [COUNT_W-1:0]        m_entry_count;

    bit hold_request = 1'b0;  // sender asks the sink for one long hold-off
    bit steady       = 1'b0;  // tail of the run: no idling on either side

    pq_scoreboard sb;

    sorted_priority_queue #(
        .CAPACITY(CAP)
    ) DUT (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_opcode        (s_opcode),
        .s_value         (s_value),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_status        (m_status),
        .m_removed_value (m_removed_value),
        .m_entry_count   (m_entry_count)
    );

    // 2 ns clock
    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    // Results are sampled on the edge with pre-edge values, so ordering within
    // the time step does not matter.
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready)
            sb.check_result(m_status, m_removed_value, m_entry_count);
    end

    // Offer one item and hold it until the block takes it. Called at a clock
    // edge; returns at the edge where the item was accepted, valid still high.
    task automatic push_op(input logic op, input logic signed [VALUE_W-1:0] val);
        s_valid  <= 1'b1;
        s_opcode <= op;
        s_value  <= val;
        @(posedge aclk);
        while (!s_ready)
            @(posedge aclk);
        sb.note_item(op, val);
    endtask

    task automatic idle_input(input int unsigned n);
        s_valid <= 1'b0;
        repeat (n) @(posedge aclk);
    endtask

    // Mix of extremes, a narrow band around zero (lots of ties) and full-range values.
    function automatic logic signed [VALUE_W-1:0] pick_value();
        logic signed [VALUE_W-1:0] v;
        case ($urandom_range(0, 5))
            0: begin
                v = 32'sh8000_0000;
                v = v + $urandom_range(0, 3);
            end
            1: begin
                v = 32'sh7FFF_FFFF;
                v = v - $urandom_range(0, 3);
            end
            2, 3: begin
                v = $urandom_range(0, 8);
                v = v - 4;
            end
            default: v = $urandom();
        endcase
        return v;
    endfunction

    // Result sink: random stall bursts whose density is redrawn every 20 to 60
    // draws, one long hold-off on request, and none at all in the tail.
    initial begin : result_sink
        int unsigned stall_pct;
        int unsigned window;
        stall_pct = 20;
        window    = 0;
        @(posedge aclk);
        forever begin
            if (window == 0) begin
                case ($urandom_range(0, 2))
                    0: stall_pct = 0;
                    1: stall_pct = 20;
                    default: stall_pct = 50;
                endcase
                window = $urandom_range(20, 60);
            end
            window--;
            if (hold_request) begin
                m_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
                hold_request = 1'b0;
            end else if (!steady && $urandom_range(0, 99) < stall_pct) begin
                m_ready <= 1'b0;
                repeat ($urandom_range(1, 7)) @(posedge aclk);
            end else begin
                m_ready <= 1'b1;
                @(posedge aclk);
            end
        end
    end

    // Main sequence: reset, directed corner items, random segments, drain, verdict.
    initial begin : stimulus
        int unsigned               seg;
        int unsigned               k;
        int unsigned               ins_pct;
        int unsigned               idle_pct;
        int unsigned               wait_cycles;
        bit                        rush;
        logic                      op;
        logic signed [VALUE_W-1:0] val;

        sb = new(CAP);
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed: remove on empty with a junk value, both extremes, zero and
        // +-1, ties, removes carrying junk values, drain to empty and one more.
        push_op(OP_REMOVE, 32'sh1234_5678);
        push_op(OP_INSERT, 32'sh7FFF_FFFF);
        push_op(OP_INSERT, 32'sh8000_0000);
        push_op(OP_INSERT, 32'sh0000_0000);
        push_op(OP_INSERT, -32'sd1);
        push_op(OP_INSERT, 32'sd1);
        push_op(OP_INSERT, -32'sd1);
        push_op(OP_INSERT, 32'sh7FFF_FFFF);
        push_op(OP_REMOVE, 32'shFFFF_FFFF);
        push_op(OP_REMOVE, 32'sh0000_0000);
        push_op(OP_INSERT, 32'sh8000_0000);
        for (k = 0; k < 7; k++)
            push_op(OP_REMOVE, $urandom());

        // Random: each segment leans toward inserts or removes, or mixes them evenly, so
        // the queue swings between full (inserts dropped) and empty (removes refused).
        for (seg = 0; seg < SEGMENTS; seg++) begin
            case (seg)
                0: ins_pct = 90;
                1: ins_pct = 10;
                default: begin
                    case ($urandom_range(0, 2))
                        0: ins_pct = 85;
                        1: ins_pct = 50;
                        default: ins_pct = 15;
                    endcase
                end
            endcase
            case ($urandom_range(0, 2))
                0: idle_pct = 0;
                1: idle_pct = 20;
                default: idle_pct = 45;
            endcase
            rush = 1'b0;
            if (seg == 4) begin
                // sink holds off for a long stretch while the sender keeps offering items
                rush         = 1'b1;
                hold_request = 1'b1;
            end
            if (seg == 7) begin
                // sender pause until the block has handed back every result
                idle_input(1);
                while (sb.awaited.size() != 0)
                    @(posedge aclk);
            end
            if (seg == CALM_FROM)
                steady = 1'b1;

            for (k = 0; k < SEG_ITEMS; k++) begin
                op  = ($urandom_range(0, 99) < ins_pct) ? OP_INSERT : OP_REMOVE;
                val = (op == OP_INSERT) ? pick_value() : $urandom();
                push_op(op, val);
                if (!steady && !rush && $urandom_range(0, 99) < idle_pct)
                    idle_input($urandom_range(1, 7));
            end
        end
        s_valid <= 1'b0;

        // Drain with a bound; anything still owed afterwards is a failure.
        wait_cycles = 0;
        while (sb.awaited.size() != 0 && wait_cycles < 2000) begin
            @(posedge aclk);
            wait_cycles++;
        end
        repeat (4) @(posedge aclk);
        if (sb.awaited.size() != 0) begin
            $display("%0d result(s) never arrived", sb.awaited.size());
            sb.mismatches += sb.awaited.size();
        end

        if (sb.mismatches == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

    // Watchdog: far beyond the slowest legal run.
    initial begin : watchdog
        #400000;
        $display("CHECKS FAILED");
        $finish;
    end

endmodule
